>>> sv/bats_pkg.sv
// ----------------------------------------------------------------------------
// Burst assembler package
// Request kinds, register map, reset values and default sizes used by the
// burst assembler.
// ----------------------------------------------------------------------------
package bats_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] REQ_PACKET = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

	// Register indexes (byte address = 4 * index).
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_LIMIT   = 2'd1;
	localparam logic [1:0] REG_HEADER  = 2'd2;
	localparam logic [1:0] REG_ACKBYP  = 2'd3;

	localparam logic [15:0] TIMEOUT_RST = 16'd100;
	localparam logic [15:0] LIMIT_RST   = 16'd24064;
	localparam logic [9:0]  HEADER_RST  = 10'd64;

	localparam int DEF_NUM_DEST    = 8;
	localparam int DEF_NUM_QUEUES  = 2;
	localparam int DEF_BURST_SLOTS = 16;

	// At most this many bursts leave for one tick.
	localparam int MAX_OUT = 16;

	// Queue offset subtracted from the first route address.
	localparam int ROUTE_BASE = 2;

endpackage

>>> sv/burst_assembler_timer_size.sv
// ----------------------------------------------------------------------------
// Burst assembler with timer and size thresholds
// Per-queue burst state in a synchronous memory, updated read-modify-write.
// ----------------------------------------------------------------------------
// Sequence: a packet or flush request is accepted, its queue entry is read and
// updated, and a burst it emits is handed to the output in the done state; a tick
// reads and updates each queue in turn and stops early once MAX_OUT bursts left.
// One request at a time: the input is not ready again until the request is done,
// and m_tready can hold back a burst and so stall the request.
// Reset: arst_n clears control, registers to defaults and the queue valid bits.
module burst_assembler_timer_size
	import bats_pkg::*;
#(
	parameter int NUM_DEST    = DEF_NUM_DEST,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int BURST_SLOTS = DEF_BURST_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request input.
	input  logic        s_tvalid,
	output logic        s_tready,
	// dest_node[2:0], route_head[10:3], queue_index[11], ingress_node[19:12],
	// packet_bytes[35:20], is_ack[36], flow_tag[44:37], packet_handle[60:45]
	input  logic [63:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	// Burst output.
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_dest[2:0], out_queue[3], out_ident[35:4], out_count[40:36],
	// out_bytes[56:41], out_source[64:57], out_flow_tag[72:65]
	output logic [79:0] m_tdata,
	// out_ack[0]
	output logic        m_tuser,
	output logic        m_tlast,
	// Configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NQ  = NUM_DEST * NUM_QUEUES;
	localparam int AW  = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int DW  = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW  = $clog2(BURST_SLOTS + 1);
	localparam int HD  = NQ * BURST_SLOTS;
	localparam int HW  = (HD > 1) ? $clog2(HD) : 1;
	localparam int EW  = $clog2(MAX_OUT + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_PROC = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Configuration registers. pready is always high, so a write lands at
	// the access cycle.
	logic [15:0] timeout_q, limit_q;
	logic [9:0]  header_q;
	logic        ackbyp_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			limit_q   <= LIMIT_RST;
			header_q  <= HEADER_RST;
			ackbyp_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
				REG_LIMIT:   limit_q   <= pwdata[15:0];
				REG_HEADER:  header_q  <= pwdata[9:0];
				REG_ACKBYP:  ackbyp_q  <= pwdata[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			REG_LIMIT:   prdata = {16'd0, limit_q};
			REG_HEADER:  prdata = {22'd0, header_q};
			REG_ACKBYP:  prdata = {31'd0, ackbyp_q};
			default:     prdata = '0;
		endcase
	end

	// Queue select table: (route - 2) mod NUM_QUEUES for every route value.
	logic [QW-1:0] qmap [256];
	for (genvar r = 0; r < 256; r++) begin : g_qmap
		assign qmap[r] = QW'((r + ROUTE_BASE * NUM_QUEUES - ROUTE_BASE) % NUM_QUEUES);
	end

	// Unpacked input fields.
	logic [2:0]  in_dest;
	logic [7:0]  in_route;
	logic        in_qidx;
	logic        in_accept;
	logic        in_ok;

	assign in_dest   = s_tdata[2:0];
	assign in_route  = s_tdata[10:3];
	assign in_qidx   = s_tdata[11];
	assign in_accept = s_tvalid & s_tready;

	always_comb begin
		case (s_tuser)
			REQ_PACKET: in_ok = (32'(in_dest) < NUM_DEST);
			REQ_TICK:   in_ok = 1'b1;
			REQ_FLUSH:  in_ok = (32'(in_dest) < NUM_DEST) && (32'(in_qidx) < NUM_QUEUES);
			default:    in_ok = 1'b0;
		endcase
	end

	// Latched request.
	logic [1:0]  state_q;
	logic [1:0]  req_q;
	logic [7:0]  ingress_q, flow_in_q;
	logic [15:0] pbytes_q, handle_q;
	logic        is_ack_q;
	logic [DW-1:0] cur_dest_q;
	logic [QW-1:0] cur_queue_q;
	logic [AW-1:0] addr;
	logic [EW-1:0] emit_cnt_q;
	logic [31:0]   next_ident_q;

	assign addr     = AW'(cur_dest_q * NUM_QUEUES + cur_queue_q);
	assign s_tready = (state_q == ST_IDLE);

	// Queue state memory: one entry per flow queue, one read port with
	// registered data, one write port; the handle store holds one entry per
	// burst slot of each queue. Entries without a valid bit read as their reset value.
	logic [CW-1:0] cnt_mem [NQ];
	logic [15:0]   byt_mem [NQ];
	logic [15:0]   tmr_mem [NQ];
	logic          pnd_mem [NQ];
	logic [31:0]   idt_mem [NQ];
	logic [7:0]    src_mem [NQ];
	logic [7:0]    flw_mem [NQ];
	logic [15:0]   hs_mem  [HD];
	logic [NQ-1:0] vld_q;

	logic [CW-1:0] cnt_rd;
	logic [15:0]   byt_rd, tmr_rd;
	logic          pnd_rd;
	logic [31:0]   idt_rd;
	logic [7:0]    src_rd, flw_rd;

	always_ff @(posedge clk) begin
		cnt_rd <= cnt_mem[addr];
		byt_rd <= byt_mem[addr];
		tmr_rd <= tmr_mem[addr];
		pnd_rd <= pnd_mem[addr];
		idt_rd <= idt_mem[addr];
		src_rd <= src_mem[addr];
		flw_rd <= flw_mem[addr];
	end

	// Effective entry.
	logic          e_vld;
	logic [CW-1:0] e_cnt;
	logic [15:0]   e_byt, e_tmr;
	logic          e_pnd;
	logic [31:0]   e_idt;
	logic [7:0]    e_src, e_flw;

	assign e_vld = vld_q[addr];
	assign e_cnt = e_vld ? cnt_rd : '0;
	assign e_byt = e_vld ? byt_rd : '0;
	assign e_tmr = e_vld ? tmr_rd : '0;
	assign e_pnd = e_vld ? pnd_rd : 1'b0;
	assign e_idt = e_vld ? idt_rd : (32'(addr) + 32'd1);
	assign e_src = e_vld ? src_rd : '0;
	assign e_flw = e_vld ? flw_rd : '0;

	// Update of the entry being processed.
	logic          wr_en, hs_en, emit, ack_emit, tick_full, last_queue;
	logic [CW-1:0] n_cnt;
	logic [15:0]   n_byt, n_tmr, emit_bytes, b0;
	logic          n_pnd;
	logic [7:0]    n_src, n_flw;
	logic [16:0]  sum;
	logic [HW-1:0] hs_addr;

	assign tick_full  = (emit_cnt_q == EW'(MAX_OUT));
	assign last_queue = (32'(addr) == NQ - 1);
	assign hs_addr    = HW'(addr * BURST_SLOTS + e_cnt);
	assign b0         = (e_cnt == '0) ? 16'(header_q) : e_byt;
	assign sum        = {1'b0, b0} + {1'b0, pbytes_q};

	always_comb begin
		wr_en      = 1'b0;
		hs_en      = 1'b0;
		emit       = 1'b0;
		ack_emit   = 1'b0;
		n_cnt      = e_cnt;
		n_byt      = e_byt;
		n_tmr      = e_tmr;
		n_pnd      = e_pnd;
		n_src      = e_src;
		n_flw      = e_flw;
		emit_bytes = e_byt;
		case (req_q)
			REQ_PACKET: begin
				wr_en = 1'b1;
				n_src = ingress_q;
				if (NUM_QUEUES != 1) begin
					n_flw = flow_in_q;
				end
				if (e_cnt == '0) begin
					n_tmr = timeout_q;
					n_pnd = 1'b1;
				end
				if (e_cnt < CW'(BURST_SLOTS)) begin
					hs_en = 1'b1;
					n_cnt = e_cnt + CW'(1);
				end
				n_byt = sum[16] ? 16'hFFFF : sum[15:0];
				if (ackbyp_q && is_ack_q) begin
					emit       = 1'b1;
					ack_emit   = 1'b1;
					emit_bytes = pbytes_q;
				end else if (n_byt >= limit_q || n_cnt >= CW'(BURST_SLOTS)) begin
					emit       = 1'b1;
					emit_bytes = n_byt;
				end
			end
			REQ_TICK: begin
				if (!tick_full && e_pnd) begin
					wr_en = 1'b1;
					if (e_tmr <= 16'd1) begin
						emit = 1'b1;
					end else begin
						n_tmr = e_tmr - 16'd1;
					end
				end
			end
			REQ_FLUSH: begin
				if (e_pnd) begin
					wr_en = 1'b1;
					emit  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register plus a held-back burst, so the last burst of a request
	// can be flagged once the request is known to be over.
	logic        m_tvalid_q, pend_v_q;
	logic [72:0] m_data_q, pend_data_q;
	logic        m_ack_q, pend_ack_q, m_last_q;
	logic        out_free, stall, advance, out_load;
	logic [72:0] new_data;

	assign out_free = !m_tvalid_q || m_tready;
	assign stall    = emit && pend_v_q && !out_free;
	assign advance  = (state_q == ST_PROC) && !stall;
	// The held-back burst moves to the output when a newer one replaces it,
	// or when the request is over.
	assign out_load = (advance && emit && pend_v_q) ||
		(state_q == ST_DONE && pend_v_q && out_free);
	assign new_data = {n_flw, n_src, emit_bytes, 5'(n_cnt), e_idt,
		1'(cur_queue_q), 3'(cur_dest_q)};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_data_q};
	assign m_tuser  = m_ack_q;
	assign m_tlast  = m_last_q;

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			cnt_mem[addr] <= emit ? '0 : n_cnt;
			byt_mem[addr] <= emit ? '0 : n_byt;
			tmr_mem[addr] <= emit ? '0 : n_tmr;
			pnd_mem[addr] <= emit ? 1'b0 : n_pnd;
			idt_mem[addr] <= emit ? next_ident_q : e_idt;
			src_mem[addr] <= n_src;
			flw_mem[addr] <= n_flw;
		end
		if (advance && hs_en) begin
			hs_mem[hs_addr] <= handle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_q        <= '0;
			next_ident_q <= 32'(NQ + 1);
			emit_cnt_q   <= '0;
			pend_v_q     <= 1'b0;
			m_tvalid_q   <= 1'b0;
			cur_dest_q   <= '0;
			cur_queue_q  <= '0;
			req_q        <= REQ_PACKET;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						req_q      <= s_tuser;
						emit_cnt_q <= '0;
						if (s_tuser == REQ_TICK) begin
							cur_dest_q  <= '0;
							cur_queue_q <= '0;
						end else begin
							cur_dest_q  <= DW'(in_dest);
							cur_queue_q <= (s_tuser == REQ_PACKET) ? qmap[in_route]
								: QW'(in_qidx);
						end
						if (in_ok) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					if (advance) begin
						if (wr_en) begin
							vld_q[addr] <= 1'b1;
						end
						if (emit) begin
							pend_v_q   <= 1'b1;
							emit_cnt_q <= emit_cnt_q + EW'(1);
							next_ident_q <= (next_ident_q == 32'hFFFF_FFFF) ? 32'd1
								: next_ident_q + 32'd1;
						end
						if (req_q == REQ_TICK && !tick_full && !last_queue) begin
							state_q <= ST_RD;
							if (32'(cur_queue_q) == NUM_QUEUES - 1) begin
								cur_queue_q <= '0;
								cur_dest_q  <= cur_dest_q + DW'(1);
							end else begin
								cur_queue_q <= cur_queue_q + QW'(1);
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload of the output and hold-back registers.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (pend_v_q) begin
				m_data_q <= pend_data_q;
				m_ack_q  <= pend_ack_q;
				m_last_q <= 1'b0;
			end
			pend_data_q <= new_data;
			pend_ack_q  <= ack_emit;
		end else if (state_q == ST_DONE && pend_v_q && out_free) begin
			m_data_q <= pend_data_q;
			m_ack_q  <= pend_ack_q;
			m_last_q <= 1'b1;
		end
	end

	// Latch the payload of an accepted request.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ingress_q <= s_tdata[19:12];
			pbytes_q  <= s_tdata[35:20];
			is_ack_q  <= s_tdata[36];
			flow_in_q <= s_tdata[44:37];
			handle_q  <= s_tdata[60:45];
		end
	end

	// The held-back burst only exists while a request is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (state_q != ST_IDLE))
		else $error("held-back burst outside a request");

	// No request may emit more bursts than a tick allows.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= EW'(MAX_OUT))
		else $error("too many bursts for one request");

	// Identifier zero is never handed out.
	assert property (@(posedge clk) disable iff (!arst_n)
		next_ident_q != 32'd0)
		else $error("burst identifier zero");

	// Every emitted burst advances the identifier.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (next_ident_q != $past(next_ident_q)))
		else $error("identifier not advanced on send");

endmodule
